FILE: rtl/bsa_pkg.sv
// bsa_pkg: shared widths, op codes and status codes for the bitmap slot allocator.
// No dependencies; every other file in rtl/ imports it.
package bsa_pkg;

  localparam int WORD_BITS      = 32;
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int POOL_SLOTS_DEF = 1024;

  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int LIM_W = 6;
  localparam int ST_W  = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [OP_W-1:0]      op_t;
  typedef logic [ST_W-1:0]      status_t;

  localparam op_t OP_ALLOC  = 2'd0;
  localparam op_t OP_FREE   = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam word_t FULL_WORD = 32'hFFFF_FFFF;

endpackage

FILE: rtl/bsa_if.sv
// bsa_if: valid/ready channel interfaces for request and response words.
// Depends on bsa_pkg.
interface bsa_in_if import bsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_t                  op;
  logic [IDX_W-1:0]     slot_index;
  logic [LIM_W-1:0]     scan_limit;

  modport source (output valid, op, slot_index, scan_limit, input ready);
  modport sink   (input valid, op, slot_index, scan_limit, output ready);
endinterface

interface bsa_out_if import bsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [IDX_W-1:0]     granted_slot;
  logic                 is_taken;

  modport source (output valid, status, granted_slot, is_taken, input ready);
  modport sink   (input valid, status, granted_slot, is_taken, output ready);
endinterface

FILE: rtl/bsa_bitmap_mem.sv
// bsa_bitmap_mem: bitmap word store, one write and one registered read port.
// Depends on bsa_pkg.
module bsa_bitmap_mem import bsa_pkg::*; #(
  parameter int DEPTH = POOL_SLOTS_DEF / WORD_BITS,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bsa_word_unit.sv
// bsa_word_unit: shared per-word logic - full test, lowest clear bit, set/clear/test.
// Depends on bsa_pkg.
module bsa_word_unit import bsa_pkg::*; (
  input  word_t            word,
  input  logic [BIT_W-1:0] bit_sel,
  output logic             full,
  output logic [BIT_W-1:0] low_pos,
  output word_t            set_word,
  output word_t            clr_word,
  output logic             bit_val
);

  word_t low_oh;

  // lowest clear bit isolated as a one-hot: ~w & (w + 1)
  assign low_oh   = ~word & (word + word_t'(1));
  assign full     = (word == FULL_WORD);
  assign set_word = word | low_oh;
  assign clr_word = word & ~(word_t'(1) << bit_sel);
  assign bit_val  = word[bit_sel];

  always_comb begin
    low_pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_oh[i]) begin
        low_pos = low_pos | BIT_W'(i);
      end
    end
  end

endmodule

FILE: rtl/bitmap_slot_allocator.sv
// bitmap_slot_allocator: slot pool bitmap with allocate-from-hint, free and query.
// Out-of-range and unused-op requests skip the bitmap read; free/query examine one
// word, allocate steps over k full words past the hint word (k <= scan_limit).
// One request in flight; ready stays low until its response is handed over.
// Rate is set by the single bitmap read port: one word examined per cycle.
// After reset a clearing pass writes zeros to every word, ready held low.
module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsa_in_if.sink    in_ch,
  bsa_out_if.source out_ch
);

  localparam int WORD_COUNT = POOL_SLOTS / WORD_BITS;
  localparam int WA         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SLOT_CW    = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W      = (SLOT_CW > IDX_W) ? SLOT_CW : IDX_W;

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [WA-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [WA-1:0]    w_r, w_nxt, w_adv, in_word;
  logic [LIM_W-1:0] steps_r, steps_nxt;
  logic [LIM_W-1:0] limit_r, limit_nxt;
  op_t              op_r, op_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  // staged response, then the output register
  status_t          res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_granted_r, res_granted_nxt;
  logic             res_taken_r, res_taken_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_granted_r, out_granted_nxt;
  logic             out_taken_r, out_taken_nxt;

  logic             in_fire, idx_oor;

  // memory and word unit hookup
  logic             mem_we;
  logic [WA-1:0]    mem_waddr, mem_raddr;
  word_t            mem_wdata, mem_rdata;
  logic             wu_full, wu_bit;
  logic [BIT_W-1:0] wu_pos;
  word_t            wu_set, wu_clr;

  bsa_bitmap_mem #(
    .DEPTH (WORD_COUNT),
    .AW    (WA)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bsa_word_unit u_wu (
    .word     (mem_rdata),
    .bit_sel  (bit_r),
    .full     (wu_full),
    .low_pos  (wu_pos),
    .set_word (wu_set),
    .clr_word (wu_clr),
    .bit_val  (wu_bit)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign idx_oor     = (CMP_W'(in_ch.slot_index) >= CMP_W'(POOL_SLOTS));
  assign in_word     = WA'(in_ch.slot_index >> BIT_W);

  // next word with wrap at the end of the pool
  assign w_adv = (w_r == WA'(WORD_COUNT - 1)) ? '0 : w_r + WA'(1);

  // read address: the request's word on accept, the next word while scanning
  assign mem_raddr = (state_r == S_EVAL) ? w_adv : in_word;

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    w_nxt           = w_r;
    steps_nxt       = steps_r;
    limit_nxt       = limit_r;
    op_nxt          = op_r;
    bit_nxt         = bit_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    res_taken_nxt   = res_taken_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_taken_nxt   = out_taken_r;
    mem_we          = 1'b0;
    mem_waddr       = w_r;
    mem_wdata       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // zero one bitmap word per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + WA'(1);
        if (clr_cnt_r == WA'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          w_nxt           = in_word;
          steps_nxt       = '0;
          limit_nxt       = in_ch.scan_limit;
          op_nxt          = in_ch.op;
          bit_nxt         = in_ch.slot_index[BIT_W-1:0];
          res_status_nxt  = ST_OK;
          res_granted_nxt = '0;
          res_taken_nxt   = 1'b0;
          if (in_ch.op == OP_UNUSED) begin
            state_nxt = S_DONE;
          end else if (idx_oor) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        // mem_rdata holds bitmap word w_r here
        state_nxt = S_DONE;
        case (op_r)
          OP_ALLOC: begin
            if (wu_full) begin
              if (steps_r >= limit_r) begin
                res_status_nxt = ST_NONE;
              end else begin
                steps_nxt = steps_r + LIM_W'(1);
                w_nxt     = w_adv;
                state_nxt = S_EVAL;
              end
            end else begin
              mem_we          = 1'b1;
              mem_wdata       = wu_set;
              res_granted_nxt = IDX_W'({w_r, wu_pos});
            end
          end
          OP_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = wu_clr;
          end
          OP_QUERY: begin
            res_taken_nxt = wu_bit;
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        // hand over when the output register is empty or draining this cycle
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_taken_nxt   = res_taken_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r           <= w_nxt;
    steps_r       <= steps_nxt;
    limit_r       <= limit_nxt;
    op_r          <= op_nxt;
    bit_r         <= bit_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    res_taken_r   <= res_taken_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_taken_r   <= out_taken_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.granted_slot = out_granted_r;
  assign out_ch.is_taken     = out_taken_r;

  // the scan never steps past the requested word count
  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> steps_r <= limit_r)
    else $error("scan stepped past its limit");

  // a failed or rejected request carries no slot and no query bit
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_granted_r == '0 && !out_taken_r)
    else $error("non-ok response carries payload");

  // a bitmap write is never granted into a full word
  a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL && op_r == OP_ALLOC && mem_we |-> !wu_full)
    else $error("allocate wrote a full word");

  // an accepted request always takes the sequencer out of idle in the cycle after accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EVAL || state_r == S_DONE)
    else $error("request accepted without entering the sequencer");

endmodule
